>>> sv/uist_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uist_pkg;

    localparam int SLOTS_DEF = 16;

    localparam int CMD_W  = 3;
    localparam int ID_W   = 64;
    localparam int SLOT_W = 4;
    localparam int MASK_W = 16;
    localparam int STAT_W = 2;

    localparam int IN_BITS  = CMD_W + ID_W + SLOT_W + MASK_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = SLOT_W + ID_W + STAT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;
    localparam logic [APB_ADDR_W-1:0] ADDR_LOCAL_USER_ID = 4'h0;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP  = 3'd0,
        CMD_RESERVE = 3'd1,
        CMD_CLEAR   = 3'd2,
        CMD_SET     = 3'd3,
        CMD_SAVE    = 3'd4,
        CMD_GET     = 3'd5
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_NONE    = 2'd1,
        STAT_BADSLOT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } ctl_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> sv/uist_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module uist_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [uist_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [uist_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [uist_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output logic      [uist_pkg::ID_W-1:0]        local_user_id
);
    import uist_pkg::*;

    logic [ID_W-1:0] local_id_reg;
    logic            wr_local;

    assign pready   = 1'b1;
    assign wr_local = psel && penable && pwrite && pready && (paddr == ADDR_LOCAL_USER_ID);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_id_reg <= '0;
        end
        else if (wr_local)
        begin
            local_id_reg <= pwdata;
        end
    end

    assign prdata        = (paddr == ADDR_LOCAL_USER_ID) ? local_id_reg : '0;
    assign local_user_id = local_id_reg;

endmodule

`default_nettype wire

>>> sv/uist_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module uist_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire uist_pkg::sts_t sts,
    output uist_pkg::ctl_t      ctl
);
    import uist_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        ctl.load   = 1'b0;
        ctl.scan   = 1'b0;
        ctl.commit = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                ctl.load = s_tvalid;
            end
            ST_SCAN:
            begin
                ctl.scan = 1'b1;
            end
            ST_DRAIN:
            begin
            end
            ST_COMMIT:
            begin
                ctl.commit = sts.out_free;
            end
            default:
            begin
            end
        endcase
    end

    // A new transaction is only taken between commands, never during a scan.
    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> (state_reg == ST_SCAN))
        else $error("load did not start a scan");

    a_scan_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.scan && sts.scan_last) |=> (state_reg == ST_DRAIN))
        else $error("scan end not followed by drain");

    a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT && !sts.out_free) |=> (state_reg == ST_COMMIT))
        else $error("commit left while output busy");

endmodule

`default_nettype wire

>>> sv/uist_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module uist_datapath #(
    parameter int SLOTS = uist_pkg::SLOTS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire uist_pkg::ctl_t              ctl,
    output uist_pkg::sts_t                   sts,
    input  wire logic [uist_pkg::IN_W-1:0]   s_tdata,
    input  wire logic [uist_pkg::ID_W-1:0]   local_user_id,
    output logic      [uist_pkg::OUT_W-1:0]  m_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready
);
    import uist_pkg::*;

    localparam int IW = $clog2(SLOTS);

    // Command fields held for the whole transaction.
    cmd_t              cmd_reg;
    logic [ID_W-1:0]   id_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [MASK_W-1:0] mask_reg;

    // Slot memory with one write and one registered read port.
    logic [ID_W-1:0]   slot_mem [SLOTS];
    logic [SLOTS-1:0]  ent_valid_reg;
    logic [ID_W-1:0]   rd_data_reg;
    logic              rd_vld_reg;

    logic [IW-1:0]     rd_idx_reg;
    logic [IW-1:0]     cmp_idx_reg;
    logic              cmp_vld_reg;

    logic              hit_reg;
    logic [IW-1:0]     hit_idx_reg;
    logic              empty_reg;
    logic [IW-1:0]     empty_idx_reg;
    logic              free_reg;
    logic [IW-1:0]     free_idx_reg;
    logic [ID_W-1:0]   sel_ent_reg;
    logic [ID_W-1:0]   ent0_reg;

    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    logic [ID_W-1:0]   cmp_entry;
    logic [IW+3:0]     cmp_idx_ext;
    logic              cmp_conn;
    logic              cmp_nonzero_idx;
    logic              cmp_is_sel;
    logic              slot_ok;
    logic [IW-1:0]     slot_addr;

    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [ID_W-1:0]   wr_data;
    logic [SLOT_W-1:0] res_slot;
    logic [ID_W-1:0]   res_id;
    status_t           res_stat;

    assign cmp_entry       = rd_vld_reg ? rd_data_reg : '0;
    assign cmp_idx_ext     = {4'd0, cmp_idx_reg};
    assign cmp_conn        = (cmp_idx_ext[IW+3:4] != '0) ? 1'b1 : mask_reg[cmp_idx_ext[3:0]];
    assign cmp_nonzero_idx = (cmp_idx_reg != '0);
    assign cmp_is_sel      = (32'(cmp_idx_reg) == 32'(slot_reg));
    assign slot_ok         = (32'(slot_reg) < SLOTS);
    assign slot_addr       = IW'(slot_reg);

    assign sts.scan_last = (rd_idx_reg == IW'(SLOTS - 1));
    assign sts.out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= cmd_t'(s_tdata[2:0]);
            id_reg   <= s_tdata[66:3];
            slot_reg <= s_tdata[70:67];
            mask_reg <= s_tdata[86:71];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (ctl.scan)
        begin
            rd_data_reg <= slot_mem[rd_idx_reg];
            rd_vld_reg  <= ent_valid_reg[rd_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            ent_valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg  <= '0;
            cmp_idx_reg <= '0;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            empty_reg   <= 1'b0;
            free_reg    <= 1'b0;
        end
        else if (ctl.load)
        begin
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            empty_reg   <= 1'b0;
            free_reg    <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= ctl.scan;
            if (ctl.scan)
            begin
                cmp_idx_reg <= rd_idx_reg;
                if (!sts.scan_last)
                begin
                    rd_idx_reg <= rd_idx_reg + IW'(1);
                end
            end
            if (cmp_vld_reg && cmp_nonzero_idx)
            begin
                if (!hit_reg && cmp_entry == id_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (!empty_reg && cmp_entry == '0 && !cmp_conn)
                begin
                    empty_reg <= 1'b1;
                end
                if (!free_reg && !cmp_conn)
                begin
                    free_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_vld_reg)
        begin
            if (!cmp_nonzero_idx)
            begin
                ent0_reg <= cmp_entry;
            end
            if (cmp_is_sel)
            begin
                sel_ent_reg <= cmp_entry;
            end
            if (cmp_nonzero_idx && !hit_reg && cmp_entry == id_reg)
            begin
                hit_idx_reg <= cmp_idx_reg;
            end
            if (cmp_nonzero_idx && !empty_reg && cmp_entry == '0 && !cmp_conn)
            begin
                empty_idx_reg <= cmp_idx_reg;
            end
            if (cmp_nonzero_idx && !free_reg && !cmp_conn)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
        end
    end

    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = cmp_idx_reg;
        wr_data  = '0;
        res_slot = '0;
        res_id   = '0;
        res_stat = STAT_OK;
        if (cmp_vld_reg && cmd_reg == CMD_CLEAR && id_reg != '0 && cmp_entry == id_reg)
        begin
            wr_en = 1'b1;
        end
        if (ctl.commit)
        begin
            case (cmd_reg)
                CMD_LOOKUP:
                begin
                    if (id_reg != '0 && hit_reg)
                    begin
                        res_slot = SLOT_W'(hit_idx_reg);
                    end
                    else
                    begin
                        res_stat = STAT_NONE;
                    end
                end
                CMD_RESERVE:
                begin
                    if (id_reg == '0)
                    begin
                        res_stat = STAT_NONE;
                    end
                    else if (hit_reg)
                    begin
                        res_slot = SLOT_W'(hit_idx_reg);
                    end
                    else if (empty_reg)
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = empty_idx_reg;
                        wr_data  = id_reg;
                        res_slot = SLOT_W'(empty_idx_reg);
                    end
                    else if (free_reg)
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = free_idx_reg;
                        wr_data  = id_reg;
                        res_slot = SLOT_W'(free_idx_reg);
                    end
                    else
                    begin
                        res_stat = STAT_NONE;
                    end
                end
                CMD_CLEAR:
                begin
                end
                CMD_SET:
                begin
                    if (slot_ok)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = slot_addr;
                        wr_data = id_reg;
                    end
                    else
                    begin
                        res_stat = STAT_BADSLOT;
                    end
                end
                CMD_SAVE:
                begin
                    if (slot_reg == '0 || !slot_ok)
                    begin
                        res_stat = STAT_BADSLOT;
                    end
                    else if (id_reg != '0)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = slot_addr;
                        wr_data = id_reg;
                    end
                    else if (sel_ent_reg == '0)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = slot_addr;
                        wr_data = ent0_reg;
                    end
                end
                CMD_GET:
                begin
                    if (slot_reg == '0)
                    begin
                        res_id = local_user_id;
                    end
                    else if (slot_ok)
                    begin
                        res_id = sel_ent_reg;
                    end
                    else
                    begin
                        res_stat = STAT_BADSLOT;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            out_data_reg <= OUT_W'({res_stat, res_id, res_slot});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmp_vld_reg && ctl.commit))
        else $error("scan compare overlaps commit");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(rd_idx_reg) < SLOTS)
        else $error("read index beyond table");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> out_valid_reg)
        else $error("committed result not presented");

endmodule

`default_nettype wire

>>> sv/user_id_slot_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Maps 64-bit user ids to player slots, with slot zero kept for the local user.
// Each command transaction reads every slot once through the single read port of
// the slot memory. The result is registered. An accepted command steps through
// the scan, drain and commit states, and the next command is accepted only once
// the previous one has been committed. A result is held on the master side
// until taken while the next command is already scanning; that command then waits
// before presenting its own result until the held one has been taken.
module user_id_slot_table #(
    parameter int SLOTS = uist_pkg::SLOTS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // cmd[2:0], user_id[66:3], slot[70:67], connected_mask[86:71], zero pad
    input  wire logic [uist_pkg::IN_W-1:0]        s_tdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // result_slot[3:0], result_id[67:4], status[69:68], zero pad
    output logic      [uist_pkg::OUT_W-1:0]       m_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [uist_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [uist_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [uist_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready
);
    import uist_pkg::*;

    ctl_t            ctl;
    sts_t            sts;
    logic [ID_W-1:0] local_user_id;

    uist_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .local_user_id (local_user_id)
    );

    uist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    uist_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .s_tdata       (s_tdata),
        .local_user_id (local_user_id),
        .m_tdata       (m_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready)
    );

endmodule

`default_nettype wire
